@@ hdl/yrb_pkg.sv @@
// Shared constants, types and helper functions for the YUV 4:2:2 / RGB565 converter.
// Used by every module in the hdl folder; depends on nothing else.
`default_nettype none

package yrb_pkg;

  // Default number of fraction bits in the fixed-point chroma coefficients.
  localparam int CoefFracBitsDefault = 12;

  // BT.709 coefficients, scaled by ten thousand.
  localparam int CoefDenom = 10000;
  localparam int C10kBlueU  = 18556;
  localparam int C10kGreenU = 1873;
  localparam int C10kGreenV = 4681;
  localparam int C10kRedV   = 15748;

  // Chroma bytes are stored with this offset.
  localparam int ChromaOffset = 128;

  // Largest channel value.
  localparam int MaxChannel = 255;

  // RGB565 field masks.
  localparam logic [15:0] Rgb565BlueMask  = 16'h001F;
  localparam logic [15:0] Rgb565GreenMask = 16'h07E0;
  localparam logic [15:0] Rgb565RedMask   = 16'hF800;

  // Control that travels with a request from the chroma stage to the output stage.
  typedef struct packed {
    logic valid;
    logic rgb_mode;
  } stage_ctrl_t;

  // Rounds a coefficient given in ten-thousandths to frac fraction bits, half up.
  function automatic int fixed_coef(input int c10k, input int frac);
    return ((c10k << frac) + CoefDenom / 2) / CoefDenom;
  endfunction

  // RGB565 channel expansion: each field moves to the top of its byte.
  function automatic logic [7:0] rgb565_blue(input logic [15:0] word);
    logic [15:0] tmp;
    tmp = (word & Rgb565BlueMask) << 3;
    return tmp[7:0];
  endfunction

  function automatic logic [7:0] rgb565_green(input logic [15:0] word);
    logic [15:0] tmp;
    tmp = (word & Rgb565GreenMask) >> 3;
    return tmp[7:0];
  endfunction

  function automatic logic [7:0] rgb565_red(input logic [15:0] word);
    logic [15:0] tmp;
    tmp = (word & Rgb565RedMask) >> 8;
    return tmp[7:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/yuv422_rgb565_to_bgra.sv @@
// Top level of the YUV 4:2:2 / RGB565 to blue-green-red pixel-pair converter.
// Depends on yrb_pkg, yrb_chroma, yrb_lane and yrb_merge.
`default_nettype none

// Each request is one camera word of four bytes and yields one result of two pixels.
// With pixel_format at 0 the bytes are Y1 U Y2 V and are converted with BT.709
// coefficients held in fixed point with COEF_FRACTION_BITS fraction bits; each
// channel is floored and clamped to 0..255. With pixel_format at 1 the bytes are two
// little-endian RGB565 pixels, each field shifted to the top of its byte. The block
// takes one request every clock while in_stall is low, and a result is presented from the
// output register: one register stage holds the chroma products, two lanes then form the
// pixels, and the output register holds the result while out_stall is high.
// Write pixel_format only while no request is in flight.

module yuv422_rgb565_to_bgra #(
  parameter int COEF_FRACTION_BITS = yrb_pkg::CoefFracBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_zero,
  input  logic [7:0] byte_one,
  input  logic [7:0] byte_two,
  input  logic [7:0] byte_three,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] first_blue,
  output logic [7:0] first_green,
  output logic [7:0] first_red,
  output logic [7:0] second_blue,
  output logic [7:0] second_green,
  output logic [7:0] second_red
);
  import yrb_pkg::*;

  localparam int ProdW = COEF_FRACTION_BITS + 12;

  logic                    pixel_format;
  logic                    down_ready;
  stage_ctrl_t             stage_ctrl;
  logic [7:0]              q_byte_zero;
  logic [7:0]              q_byte_one;
  logic [7:0]              q_byte_two;
  logic [7:0]              q_byte_three;
  logic signed [ProdW-1:0] prod_bu;
  logic signed [ProdW-1:0] prod_gu;
  logic signed [ProdW-1:0] prod_gv;
  logic signed [ProdW-1:0] prod_rv;
  logic [7:0]              lane0_blue;
  logic [7:0]              lane0_green;
  logic [7:0]              lane0_red;
  logic [7:0]              lane1_blue;
  logic [7:0]              lane1_green;
  logic [7:0]              lane1_red;

  // Format register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= 1'b0;
    end else if (cfg_write_en) begin
      pixel_format <= cfg_data;
    end
  end

  // Shared chroma products.
  yrb_chroma #(
    .COEF_FRACTION_BITS(COEF_FRACTION_BITS)
  ) u_chroma (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_zero    (byte_zero),
    .byte_one     (byte_one),
    .byte_two     (byte_two),
    .byte_three   (byte_three),
    .pixel_format (pixel_format),
    .down_ready   (down_ready),
    .stage_ctrl   (stage_ctrl),
    .q_byte_zero  (q_byte_zero),
    .q_byte_one   (q_byte_one),
    .q_byte_two   (q_byte_two),
    .q_byte_three (q_byte_three),
    .prod_bu      (prod_bu),
    .prod_gu      (prod_gu),
    .prod_gv      (prod_gv),
    .prod_rv      (prod_rv)
  );

  // Lane for the first pixel.
  yrb_lane #(
    .COEF_FRACTION_BITS(COEF_FRACTION_BITS)
  ) u_lane0 (
    .luma    (q_byte_zero),
    .prod_bu (prod_bu),
    .prod_gu (prod_gu),
    .prod_gv (prod_gv),
    .prod_rv (prod_rv),
    .blue    (lane0_blue),
    .green   (lane0_green),
    .red     (lane0_red)
  );

  // Lane for the second pixel.
  yrb_lane #(
    .COEF_FRACTION_BITS(COEF_FRACTION_BITS)
  ) u_lane1 (
    .luma    (q_byte_two),
    .prod_bu (prod_bu),
    .prod_gu (prod_gu),
    .prod_gv (prod_gv),
    .prod_rv (prod_rv),
    .blue    (lane1_blue),
    .green   (lane1_green),
    .red     (lane1_red)
  );

  // Format selection and output register.
  yrb_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .stage_ctrl   (stage_ctrl),
    .up_ready     (down_ready),
    .q_byte_zero  (q_byte_zero),
    .q_byte_one   (q_byte_one),
    .q_byte_two   (q_byte_two),
    .q_byte_three (q_byte_three),
    .lane0_blue   (lane0_blue),
    .lane0_green  (lane0_green),
    .lane0_red    (lane0_red),
    .lane1_blue   (lane1_blue),
    .lane1_green  (lane1_green),
    .lane1_red    (lane1_red),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .first_blue   (first_blue),
    .first_green  (first_green),
    .first_red    (first_red),
    .second_blue  (second_blue),
    .second_green (second_green),
    .second_red   (second_red)
  );

endmodule

`default_nettype wire

@@ hdl/yrb_chroma.sv @@
// First pipeline stage: registers the input bytes and the four chroma products.
// Depends on yrb_pkg for coefficients and the stage control struct.
`default_nettype none

module yrb_chroma #(
  parameter int COEF_FRACTION_BITS = yrb_pkg::CoefFracBitsDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              byte_zero,
  input  logic [7:0]              byte_one,
  input  logic [7:0]              byte_two,
  input  logic [7:0]              byte_three,
  input  logic                    pixel_format,
  input  logic                    down_ready,
  output yrb_pkg::stage_ctrl_t    stage_ctrl,
  output logic [7:0]              q_byte_zero,
  output logic [7:0]              q_byte_one,
  output logic [7:0]              q_byte_two,
  output logic [7:0]              q_byte_three,
  output logic signed [COEF_FRACTION_BITS+11:0] prod_bu,
  output logic signed [COEF_FRACTION_BITS+11:0] prod_gu,
  output logic signed [COEF_FRACTION_BITS+11:0] prod_gv,
  output logic signed [COEF_FRACTION_BITS+11:0] prod_rv
);
  import yrb_pkg::*;

  localparam int CoefW = COEF_FRACTION_BITS + 2;
  localparam int ProdW = COEF_FRACTION_BITS + 12;

  localparam logic signed [CoefW-1:0] KBlueU =
    CoefW'(fixed_coef(C10kBlueU, COEF_FRACTION_BITS));
  localparam logic signed [CoefW-1:0] KGreenU =
    CoefW'(fixed_coef(C10kGreenU, COEF_FRACTION_BITS));
  localparam logic signed [CoefW-1:0] KGreenV =
    CoefW'(fixed_coef(C10kGreenV, COEF_FRACTION_BITS));
  localparam logic signed [CoefW-1:0] KRedV =
    CoefW'(fixed_coef(C10kRedV, COEF_FRACTION_BITS));

  logic              load;
  logic signed [8:0] u_diff;
  logic signed [8:0] v_diff;

  // The stage takes a new request whenever it is empty or its content moves on.
  assign in_stall = stage_ctrl.valid && !down_ready;
  assign load     = in_valid && !in_stall;

  // Remove the chroma offset.
  assign u_diff = $signed({1'b0, byte_one})   - $signed(9'(ChromaOffset));
  assign v_diff = $signed({1'b0, byte_three}) - $signed(9'(ChromaOffset));

  // Occupancy of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_ctrl.valid <= 1'b0;
    end else if (!in_stall) begin
      stage_ctrl.valid <= in_valid;
    end
  end

  // Payload: one multiplier per product, registered before use.
  always_ff @(posedge clk) begin
    if (load) begin
      stage_ctrl.rgb_mode <= pixel_format;
      q_byte_zero         <= byte_zero;
      q_byte_one          <= byte_one;
      q_byte_two          <= byte_two;
      q_byte_three        <= byte_three;
      prod_bu             <= ProdW'(KBlueU)  * ProdW'(u_diff);
      prod_gu             <= ProdW'(KGreenU) * ProdW'(u_diff);
      prod_gv             <= ProdW'(KGreenV) * ProdW'(v_diff);
      prod_rv             <= ProdW'(KRedV)   * ProdW'(v_diff);
    end
  end

  // A stall is only raised while the stage holds a request.
  a_stall_needs_content: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stage_ctrl.valid)
    else $error("stall raised while chroma stage is empty");

  // A held request keeps its products until the output stage takes it.
  a_hold_products: assert property (@(posedge clk) disable iff (rst)
    (stage_ctrl.valid && !down_ready) |=>
      (stage_ctrl.valid && $stable(prod_bu) && $stable(prod_rv)))
    else $error("chroma stage content changed while held");

endmodule

`default_nettype wire

@@ hdl/yrb_lane.sv @@
// One pixel lane: adds or subtracts the chroma products from scaled luma and clamps each channel.
// Depends on yrb_pkg for the channel limit.
`default_nettype none

module yrb_lane #(
  parameter int COEF_FRACTION_BITS = yrb_pkg::CoefFracBitsDefault
) (
  input  logic [7:0]                            luma,
  input  logic signed [COEF_FRACTION_BITS+11:0] prod_bu,
  input  logic signed [COEF_FRACTION_BITS+11:0] prod_gu,
  input  logic signed [COEF_FRACTION_BITS+11:0] prod_gv,
  input  logic signed [COEF_FRACTION_BITS+11:0] prod_rv,
  output logic [7:0]                            blue,
  output logic [7:0]                            green,
  output logic [7:0]                            red
);
  import yrb_pkg::*;

  localparam int AccW = COEF_FRACTION_BITS + 12;
  localparam int QuoW = AccW - COEF_FRACTION_BITS;

  logic signed [AccW-1:0] base;
  logic signed [AccW-1:0] acc_b;
  logic signed [AccW-1:0] acc_g;
  logic signed [AccW-1:0] acc_r;

  // Floor to an integer and clamp to the channel range.
  function automatic logic [7:0] clamp_channel(input logic signed [AccW-1:0] acc);
    logic [QuoW-1:0] quo;
    quo = acc[AccW-1:COEF_FRACTION_BITS];
    if (acc <= 0) begin
      return 8'd0;
    end else if (quo >= QuoW'(MaxChannel)) begin
      return 8'(MaxChannel);
    end else begin
      return quo[7:0];
    end
  endfunction

  // Luma scaled by the coefficient unit.
  assign base = $signed({{(AccW - 8 - COEF_FRACTION_BITS){1'b0}}, luma,
                         {COEF_FRACTION_BITS{1'b0}}});

  assign acc_b = base + prod_bu;
  assign acc_g = base - prod_gu - prod_gv;
  assign acc_r = base + prod_rv;

  assign blue  = clamp_channel(acc_b);
  assign green = clamp_channel(acc_g);
  assign red   = clamp_channel(acc_r);

endmodule

`default_nettype wire

@@ hdl/yrb_merge.sv @@
// Output stage: picks the YUV lane results or the RGB565 expansion and holds the result.
// Depends on yrb_pkg for the stage control struct and the RGB565 helpers.
`default_nettype none

module yrb_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  yrb_pkg::stage_ctrl_t stage_ctrl,
  output logic                 up_ready,
  input  logic [7:0]           q_byte_zero,
  input  logic [7:0]           q_byte_one,
  input  logic [7:0]           q_byte_two,
  input  logic [7:0]           q_byte_three,
  input  logic [7:0]           lane0_blue,
  input  logic [7:0]           lane0_green,
  input  logic [7:0]           lane0_red,
  input  logic [7:0]           lane1_blue,
  input  logic [7:0]           lane1_green,
  input  logic [7:0]           lane1_red,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           first_blue,
  output logic [7:0]           first_green,
  output logic [7:0]           first_red,
  output logic [7:0]           second_blue,
  output logic [7:0]           second_green,
  output logic [7:0]           second_red
);
  import yrb_pkg::*;

  logic [15:0] word0;
  logic [15:0] word1;
  logic        load;

  // The output register is free when empty or when its request leaves this cycle.
  assign up_ready = !out_valid || !out_stall;
  assign load     = stage_ctrl.valid && up_ready;

  // Little-endian RGB565 pixels.
  assign word0 = {q_byte_one, q_byte_zero};
  assign word1 = {q_byte_three, q_byte_two};

  // Output occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= stage_ctrl.valid;
    end
  end

  // Result register, selected by the format captured with the request.
  always_ff @(posedge clk) begin
    if (load) begin
      if (stage_ctrl.rgb_mode) begin
        first_blue   <= rgb565_blue(word0);
        first_green  <= rgb565_green(word0);
        first_red    <= rgb565_red(word0);
        second_blue  <= rgb565_blue(word1);
        second_green <= rgb565_green(word1);
        second_red   <= rgb565_red(word1);
      end else begin
        first_blue   <= lane0_blue;
        first_green  <= lane0_green;
        first_red    <= lane0_red;
        second_blue  <= lane1_blue;
        second_green <= lane1_green;
        second_red   <= lane1_red;
      end
    end
  end

  // An RGB565 result has its low bits clear; checked on the first pixel and the second blue.
  a_rgb_low_bits: assert property (@(posedge clk) disable iff (rst)
    (load && stage_ctrl.rgb_mode) |=>
      (first_blue[2:0] == 3'd0 && first_red[2:0] == 3'd0 &&
       first_green[1:0] == 2'd0 && second_blue[2:0] == 3'd0))
    else $error("RGB565 expansion left low bits set");

  // With nothing arriving, a taken result leaves the register empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !stage_ctrl.valid) |=> !out_valid)
    else $error("output register kept a delivered result");

endmodule

`default_nettype wire

@@ dv/yuv422_rgb565_to_bgra_tb.sv @@
// Self-checking testbench for the YUV 4:2:2 / RGB565 to blue-green-red pixel-pair converter.
// It depends on yrb_pkg and yuv422_rgb565_to_bgra from the hdl folder. It drives a table of
// directed camera words, then random words under random stalls, against a built-in predictor.

module yuv422_rgb565_to_bgra_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Fixed-point setup of the chroma conversion; the coefficients are worked out independently of the RTL.
  localparam int FracBits = yrb_pkg::CoefFracBitsDefault;
  localparam int ChromaBias = 128;
  localparam int KBlueU  = ((18556 << FracBits) + 5000) / 10000;
  localparam int KGreenU = ((1873 << FracBits) + 5000) / 10000;
  localparam int KGreenV = ((4681 << FracBits) + 5000) / 10000;
  localparam int KRedV   = ((15748 << FracBits) + 5000) / 10000;

  // Values of the pixel_format register.
  localparam logic FmtYuv    = 1'b0;
  localparam logic FmtRgb565 = 1'b1;

  typedef struct packed {
    logic [7:0] first_blue;
    logic [7:0] first_green;
    logic [7:0] first_red;
    logic [7:0] second_blue;
    logic [7:0] second_green;
    logic [7:0] second_red;
  } pixel_pair_t;

  // One directed camera word; the expected pair is typed in only where it is obvious.
  typedef struct packed {
    logic        fmt;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic        typed;
    pixel_pair_t want;
  } word_row_t;

  localparam pixel_pair_t NoPair = '0;
  localparam int NumRows = 15;
  localparam word_row_t DirRows [NumRows] = '{
    // Neutral chroma: black and white, then mid gray and near black.
    '{FmtYuv, 8'h00, 8'h80, 8'hFF, 8'h80, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF}},
    '{FmtYuv, 8'h80, 8'h80, 8'h01, 8'h80, 1'b1, '{8'h80, 8'h80, 8'h80, 8'h01, 8'h01, 8'h01}},
    // Chroma and luma extremes that drive the clamps both ways.
    '{FmtYuv, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, NoPair},
    '{FmtYuv, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b0, NoPair},
    '{FmtYuv, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NoPair},
    '{FmtYuv, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, NoPair},
    '{FmtYuv, 8'h10, 8'h5A, 8'hEB, 8'hF0, 1'b0, NoPair},
    '{FmtYuv, 8'hEB, 8'hFF, 8'h10, 8'h00, 1'b0, NoPair},
    '{FmtYuv, 8'h80, 8'h00, 8'h80, 8'hFF, 1'b0, NoPair},
    // RGB565: empty, full, and each field on its own.
    '{FmtRgb565, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, NoPair},
    '{FmtRgb565, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
      '{8'hF8, 8'hFC, 8'hF8, 8'hF8, 8'hFC, 8'hF8}},
    '{FmtRgb565, 8'h1F, 8'h00, 8'hE0, 8'h07, 1'b1,
      '{8'hF8, 8'h00, 8'h00, 8'h00, 8'hFC, 8'h00}},
    '{FmtRgb565, 8'h00, 8'hF8, 8'h55, 8'hAA, 1'b0, NoPair},
    '{FmtRgb565, 8'h01, 8'h08, 8'h20, 8'h00, 1'b0, NoPair},
    // Back to YUV right after a format change.
    '{FmtYuv, 8'h01, 8'h7F, 8'hFE, 8'h81, 1'b0, NoPair}
  };

  // Random phases: format and idling rate of each; the last one runs without idling.
  localparam int NumPhases = 6;
  localparam int PhaseItems = 108;
  localparam logic PhaseFmt [NumPhases] =
    '{FmtRgb565, FmtYuv, FmtRgb565, FmtYuv, FmtRgb565, FmtYuv};
  localparam int PhaseIdlePct [NumPhases] = '{30, 0, 60, 20, 40, 0};

  logic       clk;
  logic       rst;
  logic       cfg_write_en;
  logic       cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] byte_zero;
  logic [7:0] byte_one;
  logic [7:0] byte_two;
  logic [7:0] byte_three;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] first_blue;
  logic [7:0] first_green;
  logic [7:0] first_red;
  logic [7:0] second_blue;
  logic [7:0] second_green;
  logic [7:0] second_red;

  // Typed expectation that travels with the request currently on the input.
  logic        row_has_typed;
  pixel_pair_t row_typed_pair;

  pixel_pair_t expected_pairs[$];
  logic        model_format;
  int          error_count;
  int          idle_pct;
  logic        quiet_tail;

  yuv422_rgb565_to_bgra #(
    .COEF_FRACTION_BITS(FracBits)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .byte_zero(byte_zero),
    .byte_one(byte_one),
    .byte_two(byte_two),
    .byte_three(byte_three),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .first_blue(first_blue),
    .first_green(first_green),
    .first_red(first_red),
    .second_blue(second_blue),
    .second_green(second_green),
    .second_red(second_red)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Floors a Q-format accumulator and clamps it to a channel byte.
  function automatic logic [7:0] floor_clamp(input int acc);
    int q;
    if (acc <= 0) begin
      return 8'd0;
    end
    q = acc >>> FracBits;
    if (q >= 255) begin
      return 8'd255;
    end
    return q[7:0];
  endfunction

  // Expected pixel pair for one camera word under the given format.
  function automatic pixel_pair_t convert_word(input logic fmt, input logic [7:0] b0,
                                               input logic [7:0] b1, input logic [7:0] b2,
                                               input logic [7:0] b3);
    pixel_pair_t pair;
    int u, v, luma0, luma1;
    logic [15:0] w0, w1;
    if (fmt == FmtYuv) begin
      u = int'(b1) - ChromaBias;
      v = int'(b3) - ChromaBias;
      luma0 = int'(b0) << FracBits;
      luma1 = int'(b2) << FracBits;
      pair.first_blue   = floor_clamp(luma0 + KBlueU * u);
      pair.first_green  = floor_clamp(luma0 - KGreenU * u - KGreenV * v);
      pair.first_red    = floor_clamp(luma0 + KRedV * v);
      pair.second_blue  = floor_clamp(luma1 + KBlueU * u);
      pair.second_green = floor_clamp(luma1 - KGreenU * u - KGreenV * v);
      pair.second_red   = floor_clamp(luma1 + KRedV * v);
    end else begin
      w0 = {b1, b0};
      w1 = {b3, b2};
      pair.first_blue   = {w0[4:0], 3'b000};
      pair.first_green  = {w0[10:5], 2'b00};
      pair.first_red    = {w0[15:11], 3'b000};
      pair.second_blue  = {w1[4:0], 3'b000};
      pair.second_green = {w1[10:5], 2'b00};
      pair.second_red   = {w1[15:11], 3'b000};
    end
    return pair;
  endfunction

  function automatic void check_channel(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Tracks the format, predicts each accepted request and checks each accepted result.
  always @(posedge clk) begin
    pixel_pair_t want;
    pixel_pair_t got;
    if (rst) begin
      model_format = FmtYuv;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{first_blue, first_green, first_red, second_blue, second_green, second_red};
        if (expected_pairs.size() == 0) begin
          $error("result with no request pending: %h", got);
          error_count++;
        end else begin
          want = expected_pairs.pop_front();
          check_channel("first_blue", want.first_blue, got.first_blue);
          check_channel("first_green", want.first_green, got.first_green);
          check_channel("first_red", want.first_red, got.first_red);
          check_channel("second_blue", want.second_blue, got.second_blue);
          check_channel("second_green", want.second_green, got.second_green);
          check_channel("second_red", want.second_red, got.second_red);
        end
      end
      if (in_valid && !in_stall) begin
        if (row_has_typed) begin
          expected_pairs.push_back(row_typed_pair);
        end else begin
          expected_pairs.push_back(convert_word(model_format, byte_zero, byte_one,
                                                byte_two, byte_three));
        end
      end
      if (cfg_write_en) begin
        model_format = cfg_data;
      end
    end
  end

  // Output stall in random bursts, at the rate of the current phase.
  initial begin
    int burst;
    out_stall <= 1'b0;
    forever begin
      if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
        burst = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // Random byte, biased toward values that hit the clamps and chroma center.
  function automatic logic [7:0] pick_byte();
    logic [7:0] val;
    val = 8'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 6))
        0: val = 8'h00;
        1: val = 8'h01;
        2: val = 8'h7F;
        3: val = 8'h80;
        4: val = 8'h81;
        5: val = 8'hFE;
        default: val = 8'hFF;
      endcase
    end
    return val;
  endfunction

  // Presents one request and holds it until it is accepted.
  task automatic send_word(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                           input logic [7:0] b3, input logic typed, input pixel_pair_t want);
    in_valid       <= 1'b1;
    byte_zero      <= b0;
    byte_one       <= b1;
    byte_two       <= b2;
    byte_three     <= b3;
    row_has_typed  <= typed;
    row_typed_pair <= want;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Random sender gap ahead of a request.
  task automatic maybe_idle();
    int gap;
    if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every pending result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pairs.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_format(input logic fmt);
    cfg_write_en <= 1'b1;
    cfg_data     <= fmt;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Main sequence: reset, directed table, then random phases.
  initial begin
    logic cur_fmt;
    error_count = 0;
    idle_pct = 0;
    quiet_tail = 1'b0;
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_data       <= 1'b0;
    in_valid       <= 1'b0;
    byte_zero      <= 8'd0;
    byte_one       <= 8'd0;
    byte_two       <= 8'd0;
    byte_three     <= 8'd0;
    row_has_typed  <= 1'b0;
    row_typed_pair <= NoPair;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first row runs on the reset format, then the format is written explicitly.
    cur_fmt = FmtYuv;
    send_word(DirRows[0].b0, DirRows[0].b1, DirRows[0].b2, DirRows[0].b3,
              DirRows[0].typed, DirRows[0].want);
    wait_drained();
    write_format(FmtYuv);
    idle_pct = 25;
    for (int r = 1; r < NumRows; r++) begin
      if (DirRows[r].fmt != cur_fmt) begin
        wait_drained();
        write_format(DirRows[r].fmt);
        cur_fmt = DirRows[r].fmt;
      end
      maybe_idle();
      send_word(DirRows[r].b0, DirRows[r].b1, DirRows[r].b2, DirRows[r].b3,
                DirRows[r].typed, DirRows[r].want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      write_format(PhaseFmt[p]);
      idle_pct = PhaseIdlePct[p];
      quiet_tail = (p == NumPhases - 1);
      for (int i = 0; i < PhaseItems; i++) begin
        // One mid-phase pause until the pipeline has fully emptied.
        if (p == 2 && i == PhaseItems / 2) begin
          wait_drained();
        end
        maybe_idle();
        send_word(pick_byte(), pick_byte(), pick_byte(), pick_byte(), 1'b0, NoPair);
      end
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
